[rtl/core/ipv6tp_pkg.sv]
// ---------------------------------------------------------------------------
// ipv6tp_pkg: shared types and constants of the ipv6 text address parser
// token format, error codes and result layout used by the parser modules
// ---------------------------------------------------------------------------
package ipv6tp_pkg;

    localparam int GROUPS           = 8;
    localparam int GROUP_W          = 16;
    localparam int GROUP_IDX_W      = 3;
    localparam int GROUP_CNT_W      = 4;
    localparam int DIGITS_PER_GROUP = 4;
    localparam int DIGIT_CNT_W      = 3;
    localparam int CHAR_CNT_W       = 6;
    localparam int MAX_CHARS_DEF    = 39;
    localparam int CHAR_W           = 8;
    localparam int HALF_W           = 64;
    localparam int ADDR_W           = 128;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [1:0] {
        TOK_DIGIT,
        TOK_COLON,
        TOK_NUL,
        TOK_BAD
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_DOUBLE_GAP  = 3'd1,
        ERR_GROUP_LONG  = 3'd2,
        ERR_BAD_DIGIT   = 3'd3,
        ERR_MANY_COLONS = 3'd4,
        ERR_FEW_COLONS  = 3'd5,
        ERR_TOO_LONG    = 3'd6
    } err_t;

    typedef struct packed {
        logic [HALF_W-1:0] address_high;
        logic [HALF_W-1:0] address_low;
        err_t              error_code;
    } result_t;

    // handshake between the parser core and the result queue
    typedef struct packed {
        logic full;
    } res_status_t;

    typedef struct packed {
        logic take;
    } tok_ctrl_t;

endpackage

[rtl/core/ipv6_text_address_parser.sv]
// ---------------------------------------------------------------------------
// ipv6_text_address_parser: textual ipv6 address to 128-bit address
// one ascii character per item in, one address and error code per nul out
// ---------------------------------------------------------------------------
// usage
// - input channel: drive character and raise push; the item is taken at a
//   rising edge with push high and full low
// - result channel: while empty is low the oldest result sits on
//   address_high, address_low and error_code; pop high at an edge takes it
// - only a nul (character zero) yields a result; other characters update
//   the parser state and yield nothing
// - throughput: one character per cycle, nul included, sustained while no
//   nul waits on a full result queue; a taken nul sits in the two-entry token
//   queue, and the core then registers its result in the result queue
// - on an error the address halves read zero and later characters are
//   dropped until the nul, which also returns the parser to its idle state
// - reset clears both queues and all parser control state
// - if the receiver stalls, the two-entry result queue fills, the core
//   halts on the next nul and the token queue backs up until full rises;
//   characters other than nul keep flowing while only a result waits
// ---------------------------------------------------------------------------
module ipv6_text_address_parser
    import ipv6tp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] character,
    input  logic              push,
    output logic              full,
    output logic [HALF_W-1:0] address_high,
    output logic [HALF_W-1:0] address_low,
    output logic [2:0]        error_code,
    output logic              empty,
    input  logic              pop
);

    // front to core token path
    logic        tok_valid;
    token_t      tok;
    tok_ctrl_t   tok_ctrl;

    // core to result queue
    res_status_t res_status;
    logic        res_push;
    result_t     res;
    result_t     res_out;
    logic        res_full;

    ipv6tp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .character (character),
        .push      (push),
        .full      (full),
        .tok_take  (tok_ctrl.take),
        .tok_valid (tok_valid),
        .tok       (tok)
    );

    ipv6tp_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_valid  (tok_valid),
        .tok        (tok),
        .tok_ctrl   (tok_ctrl),
        .res_status (res_status),
        .res_push   (res_push),
        .res        (res)
    );

    assign res_status.full = res_full;

    // result queue parts the core from a stalling receiver
    ipv6tp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .full    (res_full),
        .wr_data (res),
        .pop     (pop),
        .empty   (empty),
        .rd_data (res_out)
    );

    assign address_high = res_out.address_high;
    assign address_low  = res_out.address_low;
    assign error_code   = 3'(res_out.error_code);

endmodule

[rtl/core/ipv6tp_fifo.sv]
// ---------------------------------------------------------------------------
// ipv6tp_fifo: small register queue
// holds items between parser stages, push/full and pop/empty handshake
// ---------------------------------------------------------------------------
module ipv6tp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/ipv6tp_front.sv]
// ---------------------------------------------------------------------------
// ipv6tp_front: character classifier
// turns each accepted character into a token and queues it for the core
// ---------------------------------------------------------------------------
module ipv6tp_front
    import ipv6tp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] character,
    input  logic              push,
    output logic              full,
    input  logic              tok_take,
    output logic              tok_valid,
    output token_t            tok
);

    token_t cls;
    logic   tok_empty;

    always_comb
    begin
        cls.kind  = TOK_BAD;
        cls.digit = '0;
        if (character == '0)
        begin
            cls.kind = TOK_NUL;
        end
        else if (character == 8'h3a)
        begin
            cls.kind = TOK_COLON;
        end
        else if (character inside {[8'h30:8'h39]})
        begin
            cls.kind  = TOK_DIGIT;
            cls.digit = 4'(character - 8'h30);
        end
        else if (character inside {[8'h61:8'h66]})
        begin
            cls.kind  = TOK_DIGIT;
            cls.digit = 4'(character - 8'h57);
        end
        else if (character inside {[8'h41:8'h46]})
        begin
            cls.kind  = TOK_DIGIT;
            cls.digit = 4'(character - 8'h37);
        end
    end

    ipv6tp_fifo #(
        .WIDTH ($bits(token_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_data (cls),
        .pop     (tok_take),
        .empty   (tok_empty),
        .rd_data (tok)
    );

    assign tok_valid = !tok_empty;

endmodule

[rtl/core/ipv6tp_back.sv]
// ---------------------------------------------------------------------------
// ipv6tp_back: parser core
// gathers hex groups, tracks the double colon and builds the address on nul
// ---------------------------------------------------------------------------
module ipv6tp_back
    import ipv6tp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tok_valid,
    input  token_t      tok,
    output tok_ctrl_t   tok_ctrl,
    input  res_status_t res_status,
    output logic        res_push,
    output result_t     res
);

    typedef logic [GROUPS-1:0][GROUP_W-1:0] grp_vec_t;

    logic [GROUP_W-1:0]     acc_reg, acc_next;
    logic [DIGIT_CNT_W-1:0] digit_count_reg, digit_count_next;
    logic [GROUP_CNT_W-1:0] groups_done_reg, groups_done_next;
    logic [GROUP_CNT_W-1:0] gap_pos_reg, gap_pos_next;
    logic                   gap_seen_reg, gap_seen_next;
    logic                   prev_colon_reg, prev_colon_next;
    logic [CHAR_CNT_W-1:0]  char_count_reg, char_count_next;
    err_t                   err_reg, err_next;
    // groups before the double colon sit at their index, later ones shift in at the bottom
    grp_vec_t               head_reg, head_next;
    grp_vec_t               tail_reg, tail_next;

    logic                   take;
    logic                   is_nul;

    logic                   fin_commit;
    logic [GROUP_CNT_W-1:0] fin_gd;
    grp_vec_t               fin_head;
    grp_vec_t               fin_tail;
    err_t                   fin_err;
    logic [GROUP_CNT_W-1:0] eff_pos;
    logic [GROUP_CNT_W-1:0] tcount;
    logic [ADDR_W-1:0]      addr;
    logic [GROUP_W-1:0]     grp;

    assign is_nul        = (tok.kind == TOK_NUL);
    assign take          = tok_valid && (!is_nul || !res_status.full);
    assign tok_ctrl.take  = take;
    assign res_push      = tok_valid && is_nul && !res_status.full;

    // end of string: pending group, final checks, gap expansion
    always_comb
    begin
        fin_commit = (digit_count_reg != '0) && (groups_done_reg < GROUP_CNT_W'(GROUPS));
        fin_gd     = groups_done_reg + GROUP_CNT_W'(fin_commit);
        fin_head   = head_reg;
        fin_tail   = tail_reg;
        if (fin_commit && !gap_seen_reg)
        begin
            fin_head[groups_done_reg[GROUP_IDX_W-1:0]] = acc_reg;
        end
        if (fin_commit && gap_seen_reg)
        begin
            fin_tail = {tail_reg[GROUPS-2:0], acc_reg};
        end

        fin_err = err_reg;
        if (err_reg == ERR_NONE)
        begin
            if (prev_colon_reg && !(gap_seen_reg && gap_pos_reg == fin_gd))
            begin
                fin_err = ERR_MANY_COLONS;
            end
            else if (gap_seen_reg && fin_gd >= GROUP_CNT_W'(GROUPS))
            begin
                fin_err = ERR_MANY_COLONS;
            end
            else if (!gap_seen_reg && fin_gd < GROUP_CNT_W'(GROUPS))
            begin
                fin_err = ERR_FEW_COLONS;
            end
        end

        eff_pos = gap_seen_reg ? gap_pos_reg : GROUP_CNT_W'(GROUPS);
        tcount  = gap_seen_reg ? fin_gd - gap_pos_reg : '0;
        addr    = '0;
        grp     = '0;
        for (int i = 0; i < GROUPS; i++)
        begin
            grp = '0;
            if (GROUP_CNT_W'(i) < eff_pos)
            begin
                grp = grp | fin_head[i];
            end
            if (GROUP_CNT_W'(i) >= GROUP_CNT_W'(GROUPS) - tcount)
            begin
                grp = grp | fin_tail[GROUPS-1-i];
            end
            addr[(GROUPS-1-i)*GROUP_W +: GROUP_W] = grp;
        end
        if (fin_err != ERR_NONE)
        begin
            addr = '0;
        end

        res.address_high = addr[ADDR_W-1:HALF_W];
        res.address_low  = addr[HALF_W-1:0];
        res.error_code   = fin_err;
    end

    // per character update
    always_comb
    begin
        acc_next         = acc_reg;
        digit_count_next = digit_count_reg;
        groups_done_next = groups_done_reg;
        gap_pos_next     = gap_pos_reg;
        gap_seen_next    = gap_seen_reg;
        prev_colon_next  = prev_colon_reg;
        char_count_next  = char_count_reg;
        err_next         = err_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;

        if (take)
        begin
            if (is_nul)
            begin
                acc_next         = '0;
                digit_count_next = '0;
                groups_done_next = '0;
                gap_pos_next     = '0;
                gap_seen_next    = 1'b0;
                prev_colon_next  = 1'b0;
                char_count_next  = '0;
                err_next         = ERR_NONE;
            end
            else if (err_reg != ERR_NONE)
            begin
                // errored string: wait for the nul
            end
            else if (char_count_reg >= CHAR_CNT_W'(MAX_CHARS))
            begin
                err_next = ERR_TOO_LONG;
            end
            else
            begin
                char_count_next = char_count_reg + 1'b1;
                case (tok.kind)
                    TOK_COLON:
                    begin
                        if (prev_colon_reg)
                        begin
                            if (gap_seen_reg)
                            begin
                                err_next = ERR_DOUBLE_GAP;
                            end
                            else
                            begin
                                gap_seen_next = 1'b1;
                                gap_pos_next  = groups_done_reg;
                            end
                        end
                        else
                        begin
                            prev_colon_next = 1'b1;
                            if (digit_count_reg != '0)
                            begin
                                acc_next         = '0;
                                digit_count_next = '0;
                                if (groups_done_reg < GROUP_CNT_W'(GROUPS))
                                begin
                                    if (gap_seen_reg)
                                    begin
                                        tail_next = {tail_reg[GROUPS-2:0], acc_reg};
                                    end
                                    else
                                    begin
                                        head_next[groups_done_reg[GROUP_IDX_W-1:0]] = acc_reg;
                                    end
                                    groups_done_next = groups_done_reg + 1'b1;
                                end
                                if (groups_done_next >= GROUP_CNT_W'(GROUPS))
                                begin
                                    err_next        = ERR_MANY_COLONS;
                                    prev_colon_next = prev_colon_reg;
                                end
                            end
                        end
                    end
                    TOK_DIGIT:
                    begin
                        if (prev_colon_reg && groups_done_reg == '0 && !gap_seen_reg)
                        begin
                            err_next = ERR_MANY_COLONS;
                        end
                        else if (digit_count_reg >= DIGIT_CNT_W'(DIGITS_PER_GROUP))
                        begin
                            err_next = ERR_GROUP_LONG;
                        end
                        else
                        begin
                            acc_next         = {acc_reg[GROUP_W-5:0], tok.digit};
                            digit_count_next = digit_count_reg + 1'b1;
                            prev_colon_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        err_next = ERR_BAD_DIGIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            digit_count_reg <= '0;
            groups_done_reg <= '0;
            gap_pos_reg     <= '0;
            gap_seen_reg    <= 1'b0;
            prev_colon_reg  <= 1'b0;
            char_count_reg  <= '0;
            err_reg         <= ERR_NONE;
        end
        else
        begin
            acc_reg         <= acc_next;
            digit_count_reg <= digit_count_next;
            groups_done_reg <= groups_done_next;
            gap_pos_reg     <= gap_pos_next;
            gap_seen_reg    <= gap_seen_next;
            prev_colon_reg  <= prev_colon_next;
            char_count_reg  <= char_count_next;
            err_reg         <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

[test/ipv6_text_address_parser_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipv6_text_address_parser_tb: self-checking bench for the ipv6 text parser
// feeds address strings one character per item, predicts addresses and error
// codes with a behavioural parser or a typed answer and checks each popped result in order
// ---------------------------------------------------------------------------
module ipv6_text_address_parser_tb;
    import ipv6tp_pkg::*;

    localparam int MAX_CHARS       = MAX_CHARS_DEF;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int TAIL_CYCLES     = 8;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIRECTED_ROWS   = 27;

    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
    localparam logic [CHAR_W-1:0] COLON_CHAR = ":";

    // kinds of random string
    localparam int TEXT_WELL_FORMED = 0;
    localparam int TEXT_MUTATED     = 1;
    localparam int TEXT_NOISE       = 2;

    typedef logic [CHAR_W-1:0] byte_text_t [$];

    // a directed row either carries its answer typed in or leaves it to the parser model
    typedef struct packed {
        logic    typed;
        result_t value;
    } directed_answer_t;

    localparam directed_answer_t PREDICTED = '{1'b0, '{64'h0, 64'h0, ERR_NONE}};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic [CHAR_W-1:0] character = '0;
    logic              push      = 1'b0;
    logic              full;
    logic [HALF_W-1:0] address_high;
    logic [HALF_W-1:0] address_low;
    logic [2:0]        error_code;
    logic              empty;
    logic              pop       = 1'b0;

    // behavioural parser state
    logic [GROUP_W-1:0] stored_groups [GROUPS];
    logic [GROUP_W-1:0] group_acc;
    int                 digits_taken;
    int                 groups_taken;
    int                 gap_at;
    bit                 gap_found;
    bit                 after_colon;
    int                 chars_taken;
    err_t               held_error;

    result_t pending_addresses [$];
    result_t oldest;

    int mismatches      = 0;
    int results_checked = 0;
    int strings_sent    = 0;
    int chars_sent      = 0;
    int cycle_count     = 0;
    int outcome_count [8];

    bit no_idle        = 1'b0;
    bit stall_receiver = 1'b0;
    bit stall_active   = 1'b0;

    string directed_text [DIRECTED_ROWS] = '{
        "",
        "::",
        "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff",
        "0:0:0:0:0:0:0:0",
        "1:2:3:4:5:6:7:8",
        "::1",
        "1::",
        "12ab::CDEF:9",
        "Fe80::a:B:c",
        "1:2:3:4:5:6:7::",
        "::1:2:3:4:5:6:7",
        "1::2::3",
        ":::",
        "12345::",
        "1:g::",
        "\377",
        "\001::",
        "x::::",
        ":1::",
        ":",
        "1::2:",
        "1:2:3:4:5:6:7:8:",
        "1:2:3:4::5:6:7:8",
        "1:2:3",
        "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff:",
        "1:2:3:4:5:6:7:8:x",
        "AbCd:eF01::"
    };

    directed_answer_t directed_answer [DIRECTED_ROWS] = '{
        '{1'b1, '{64'h0, 64'h0, ERR_FEW_COLONS}},
        '{1'b1, '{64'h0, 64'h0, ERR_NONE}},
        '{1'b1, '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, ERR_NONE}},
        '{1'b1, '{64'h0, 64'h0, ERR_NONE}},
        PREDICTED,
        PREDICTED,
        PREDICTED,
        PREDICTED,
        PREDICTED,
        PREDICTED,
        PREDICTED,
        '{1'b1, '{64'h0, 64'h0, ERR_DOUBLE_GAP}},
        '{1'b1, '{64'h0, 64'h0, ERR_DOUBLE_GAP}},
        '{1'b1, '{64'h0, 64'h0, ERR_GROUP_LONG}},
        '{1'b1, '{64'h0, 64'h0, ERR_BAD_DIGIT}},
        '{1'b1, '{64'h0, 64'h0, ERR_BAD_DIGIT}},
        '{1'b1, '{64'h0, 64'h0, ERR_BAD_DIGIT}},
        '{1'b1, '{64'h0, 64'h0, ERR_BAD_DIGIT}},
        '{1'b1, '{64'h0, 64'h0, ERR_MANY_COLONS}},
        '{1'b1, '{64'h0, 64'h0, ERR_MANY_COLONS}},
        '{1'b1, '{64'h0, 64'h0, ERR_MANY_COLONS}},
        '{1'b1, '{64'h0, 64'h0, ERR_MANY_COLONS}},
        '{1'b1, '{64'h0, 64'h0, ERR_MANY_COLONS}},
        '{1'b1, '{64'h0, 64'h0, ERR_FEW_COLONS}},
        '{1'b1, '{64'h0, 64'h0, ERR_TOO_LONG}},
        '{1'b1, '{64'h0, 64'h0, ERR_MANY_COLONS}},
        PREDICTED
    };

    ipv6_text_address_parser #(
        .MAX_CHARS (MAX_CHARS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .character    (character),
        .push         (push),
        .full         (full),
        .address_high (address_high),
        .address_low  (address_low),
        .error_code   (error_code),
        .empty        (empty),
        .pop          (pop)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // behavioural parser
    // ------------------------------------------------------------------

    function automatic void clear_parse_state();
        for (int i = 0; i < GROUPS; i++)
        begin
            stored_groups[i] = '0;
        end
        group_acc    = '0;
        digits_taken = 0;
        groups_taken = 0;
        gap_at       = 0;
        gap_found    = 1'b0;
        after_colon  = 1'b0;
        chars_taken  = 0;
        held_error   = ERR_NONE;
    endfunction

    // a ninth group is dropped, the overflow is caught by the caller
    function automatic void close_group();
        if (groups_taken < GROUPS)
        begin
            stored_groups[groups_taken] = group_acc;
            groups_taken++;
        end
        group_acc    = '0;
        digits_taken = 0;
    endfunction

    // updates the parser with one accepted character, returns 1 with the
    // finished address on a nul
    function automatic bit parse_char(input logic [CHAR_W-1:0] c, output result_t res);
        int                 value;
        int                 zeros;
        int                 split;
        int                 src;
        logic [GROUP_W-1:0] g [GROUPS];
        res = '0;
        if (c == NUL_CHAR)
        begin
            if (held_error == ERR_NONE)
            begin
                if (digits_taken > 0)
                    close_group();
                // a trailing colon is fine only as the second half of a double colon
                if (after_colon && !(gap_found && gap_at == groups_taken))
                    held_error = ERR_MANY_COLONS;
                else if (gap_found && groups_taken >= GROUPS)
                    held_error = ERR_MANY_COLONS;
                else if (!gap_found && groups_taken < GROUPS)
                    held_error = ERR_FEW_COLONS;
            end
            if (held_error == ERR_NONE)
            begin
                // the double colon expands to the missing zero groups
                zeros = gap_found ? GROUPS - groups_taken : 0;
                split = gap_found ? gap_at : GROUPS;
                for (int i = 0; i < GROUPS; i++)
                begin
                    g[i] = '0;
                    src  = i - zeros;
                    if (i < split)
                    begin
                        if (i < groups_taken)
                            g[i] = stored_groups[i];
                    end
                    else if (i >= split + zeros && src < groups_taken)
                        g[i] = stored_groups[src];
                end
                res.address_high = {g[0], g[1], g[2], g[3]};
                res.address_low  = {g[4], g[5], g[6], g[7]};
            end
            res.error_code = held_error;
            clear_parse_state();
            return 1'b1;
        end
        // first error wins, the rest of the string is dropped
        if (held_error != ERR_NONE)
            return 1'b0;
        if (chars_taken >= MAX_CHARS)
        begin
            held_error = ERR_TOO_LONG;
            return 1'b0;
        end
        chars_taken++;
        if (c == COLON_CHAR)
        begin
            if (after_colon)
            begin
                if (gap_found)
                    held_error = ERR_DOUBLE_GAP;
                else
                begin
                    gap_found = 1'b1;
                    gap_at    = groups_taken;
                end
            end
            else
            begin
                if (digits_taken > 0)
                begin
                    close_group();
                    if (groups_taken >= GROUPS)
                        held_error = ERR_MANY_COLONS;
                end
                after_colon = 1'b1;
            end
            return 1'b0;
        end
        if (c >= "0" && c <= "9")
            value = c - "0";
        else if (c >= "a" && c <= "f")
            value = c - "a" + 10;
        else if (c >= "A" && c <= "F")
            value = c - "A" + 10;
        else
            value = -1;
        if (value < 0)
            held_error = ERR_BAD_DIGIT;
        else if (after_colon && groups_taken == 0 && !gap_found)
            held_error = ERR_MANY_COLONS;   // lone leading colon
        else if (digits_taken >= DIGITS_PER_GROUP)
            held_error = ERR_GROUP_LONG;
        else
        begin
            group_acc = {group_acc[GROUP_W-5:0], value[3:0]};
            digits_taken++;
            after_colon = 1'b0;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] random_hex_char();
        logic [CHAR_W-1:0] d;
        logic [CHAR_W-1:0] letter_base;
        d = CHAR_W'($urandom_range(0, 15));
        letter_base = $urandom_range(0, 1) ? "a" : "A";
        if (d < 10)
            return "0" + d;
        return letter_base + d - 8'd10;
    endfunction

    // well-formed address text, optionally with one random defect, or plain noise
    function automatic byte_text_t make_address_text(input int kind);
        byte_text_t text;
        int         count;
        int         split;
        int         width;
        int         pos;
        int         pick;
        bit         with_gap;
        text = {};
        if (kind == TEXT_NOISE)
        begin
            repeat ($urandom_range(0, 45))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    text.push_back(random_hex_char());
                else if (pick < 7)
                    text.push_back(COLON_CHAR);
                else
                    text.push_back(CHAR_W'($urandom_range(1, 255)));
            end
            return text;
        end
        with_gap = $urandom_range(0, 2) != 0;
        count    = with_gap ? $urandom_range(0, GROUPS - 1) : GROUPS;
        split    = with_gap ? $urandom_range(0, count) : GROUPS;
        for (int g = 0; g < count; g++)
        begin
            if (with_gap && g == split)
            begin
                text.push_back(COLON_CHAR);
                text.push_back(COLON_CHAR);
            end
            else if (g > 0)
                text.push_back(COLON_CHAR);
            width = $urandom_range(0, 3) == 0 ? DIGITS_PER_GROUP : $urandom_range(1, 4);
            repeat (width)
                text.push_back(random_hex_char());
        end
        if (with_gap && split == count)
        begin
            text.push_back(COLON_CHAR);
            text.push_back(COLON_CHAR);
        end
        if (kind == TEXT_MUTATED && text.size() > 0)
        begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 3))
                0: text[pos] = CHAR_W'($urandom_range(1, 255));
                1: text.insert(pos, COLON_CHAR);
                2: text.insert(pos, random_hex_char());
                default: text.delete(pos);
            endcase
        end
        return text;
    endfunction

    // offers each character and the closing nul, waiting for the handshake each time
    task automatic send_string(input byte_text_t text, input directed_answer_t answer);
        result_t           predicted;
        bit                produced;
        int                gap;
        int                pick;
        logic [CHAR_W-1:0] c;
        for (int i = 0; i <= text.size(); i++)
        begin
            c   = (i == text.size()) ? NUL_CHAR : text[i];
            gap = 0;
            if (!no_idle)
            begin
                // mostly back to back, some short gaps, the odd long one
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    gap = 0;
                else if (pick < 90)
                    gap = $urandom_range(1, 3);
                else if (pick < 98)
                    gap = $urandom_range(4, 10);
                else
                    gap = $urandom_range(20, 60);
            end
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            character <= c;
            push      <= 1'b1;
            do
                @(posedge clk);
            while (full);
            chars_sent++;
            produced = parse_char(c, predicted);
            if (produced)
                pending_addresses.push_back(answer.typed ? answer.value : predicted);
        end
        strings_sent++;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        byte_text_t text;
        int         random_strings;
        int         pick;
        int         kind;
        clear_parse_state();
        for (int i = 0; i < 8; i++)
        begin
            outcome_count[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed rows: extremes, every error and the corner cases of colons
        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            text = {};
            for (int k = 0; k < directed_text[row].len(); k++)
            begin
                text.push_back(directed_text[row][k]);
            end
            no_idle = (row % 4 == 0);
            send_string(text, directed_answer[row]);
        end

        // random strings, mostly well-formed so that the deep states are reached
        random_strings = 0;
        while (chars_sent < RANDOM_ITEMS)
        begin
            if (random_strings == 15)
            begin
                // receiver holds off while the sender keeps offering items,
                // so both queues fill and full stalls the input
                push <= 1'b0;
                stall_receiver = 1'b1;
                while (!stall_active) @(posedge clk);
                no_idle = 1'b1;
                repeat (25)
                    send_string(make_address_text(TEXT_WELL_FORMED), PREDICTED);
            end
            if (random_strings == 20)
            begin
                // sender pauses until every address has come out
                push <= 1'b0;
                while (pending_addresses.size() != 0) @(posedge clk);
                repeat (TAIL_CYCLES) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
                kind = TEXT_WELL_FORMED;
            else if (pick < 85)
                kind = TEXT_MUTATED;
            else
                kind = TEXT_NOISE;
            no_idle = ($urandom_range(0, 3) == 0);
            send_string(make_address_text(kind), PREDICTED);
            random_strings++;
        end

        push <= 1'b0;
        while (pending_addresses.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d strings, %0d characters, %0d addresses checked",
                 strings_sent, chars_sent, results_checked);
        $display("outcomes: ok %0d, double gap %0d, long group %0d, bad digit %0d, %s%0d, %s%0d, %s%0d",
                 outcome_count[ERR_NONE], outcome_count[ERR_DOUBLE_GAP],
                 outcome_count[ERR_GROUP_LONG], outcome_count[ERR_BAD_DIGIT],
                 "many colons ", outcome_count[ERR_MANY_COLONS],
                 "few colons ", outcome_count[ERR_FEW_COLONS],
                 "too long ", outcome_count[ERR_TOO_LONG]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random pop pattern plus one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : result_drain
        int span;
        int pick;
        bit take;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (stall_receiver)
            begin
                stall_active = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                stall_active   = 1'b0;
                stall_receiver = 1'b0;
            end
            else
            begin
                take = ($urandom_range(0, 9) < 7);
                if (take)
                    span = $urandom_range(1, 40);
                else
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 16)
                        span = $urandom_range(1, 3);
                    else if (pick < 19)
                        span = $urandom_range(4, 10);
                    else
                        span = $urandom_range(20, 60);
                end
                pop <= take;
                repeat (span) @(posedge clk);
            end
        end
    end

    // compares every popped result with the oldest predicted address
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_addresses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: high %h low %h code %0d",
                             address_high, address_low, error_code);
            end
            else
            begin
                oldest = pending_addresses.pop_front();
                results_checked++;
                outcome_count[oldest.error_code]++;
                if (address_high !== oldest.address_high ||
                    address_low  !== oldest.address_low  ||
                    error_code   !== oldest.error_code)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: expected %h %h code %0d, got %h %h code %0d",
                                 results_checked, oldest.address_high, oldest.address_low,
                                 oldest.error_code, address_high, address_low, error_code);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d addresses outstanding",
                     cycle_count, pending_addresses.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

[filelist.f]
rtl/core/ipv6tp_pkg.sv
rtl/core/ipv6tp_fifo.sv
rtl/core/ipv6tp_front.sv
rtl/core/ipv6tp_back.sv
rtl/core/ipv6_text_address_parser.sv
test/ipv6_text_address_parser_tb.sv
